@@ rtl/core/generational_slot_allocator_defines.svh @@
// Assertion macros for the generational slot allocator.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on every clock edge outside reset.
`define GSA_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("gsa check failed");
// Check a property on every clock edge, reset included.
`define GSA_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("gsa check failed");
`else
`define GSA_ASSERT(lbl, prop)
`define GSA_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

@@ rtl/core/gsa_pkg.sv @@
// Types and constants shared by the generational slot allocator.
package gsa_pkg;

  localparam int NUM_CHUNKS      = 64;
  localparam int SLOTS_PER_CHUNK = 32;
  localparam int GEN_BITS        = 8;
  localparam int CHUNK_W         = $clog2(NUM_CHUNKS);
  localparam int SLOT_W          = $clog2(SLOTS_PER_CHUNK);
  localparam int TOTAL_SLOTS     = NUM_CHUNKS * SLOTS_PER_CHUNK;
  localparam int SLOT_ADDR_W     = CHUNK_W + SLOT_W;
  localparam int USE_W           = CHUNK_W + 1;
  localparam int INDEX_W         = 11;
  localparam int HGEN_W          = 8;
  localparam int LIMIT_W         = 7;
  localparam int LIMIT_RESET     = 64;
  localparam int PADDR_W         = 3;
  localparam int PDATA_W         = 32;

  typedef enum logic [1:0] {
    CMD_SPAWN = 2'd0,
    CMD_KILL  = 2'd1,
    CMD_CHECK = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_INVALID = 2'd2,
    STS_SPARE   = 2'd3
  } status_t;

  typedef enum logic {
    REG_CHUNK_LIMIT = 1'b0,
    REG_UNMAPPED    = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHUNK,
    ST_SLOT,
    ST_GEN,
    ST_LOOKUP
  } state_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic [INDEX_W-1:0]   handle_index;
    logic [HGEN_W-1:0]    handle_generation;
  } alloc_in_t;

  typedef struct packed {
    status_t              status;
    logic [INDEX_W-1:0]   given_index;
    logic [HGEN_W-1:0]    given_generation;
    logic                 is_live;
  } alloc_out_t;

endpackage

@@ rtl/core/generational_slot_allocator.sv @@
// Generational slot allocator: sequencer, free-bit and generation memories.
//
//   channel   ports                              handshake
//   input     start, busy, in_item               taken when start && !busy
//   result    out_strobe, out_result             one cycle, no back-pressure
//   config    psel penable pwrite paddr pwdata prdata pready   APB, pready high
//
// Kill, check and the unused command go through the lookup state; a spawn
// goes through the chunk, slot and generation states, ending early when full.
// The result strobe is high in the first cycle with busy low, and a new item
// may enter at the end of that same cycle.
// Slot, generation and lookup steps wait on registered free-bit or gen reads;
// one find-first-set unit serves both the chunk search and the slot search.
// After reset a clearing pass sets every generation to all ones and every free
// word to all ones; busy stays high throughout.
// The receiver cannot stall; busy alone holds off the sender.
`include "generational_slot_allocator_defines.svh"
module generational_slot_allocator (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  gsa_pkg::alloc_in_t       in_item,
  output logic                     out_strobe,
  output gsa_pkg::alloc_out_t      out_result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [gsa_pkg::PADDR_W-1:0] paddr,
  input  logic [gsa_pkg::PDATA_W-1:0] pwdata,
  output logic [gsa_pkg::PDATA_W-1:0] prdata,
  output logic                     pready
);
  import gsa_pkg::*;

  // Memories
  logic [SLOTS_PER_CHUNK-1:0] free_mem [NUM_CHUNKS];
  logic [GEN_BITS-1:0]        gen_mem  [TOTAL_SLOTS];

  logic                       free_we;
  logic [CHUNK_W-1:0]         free_waddr, free_raddr;
  logic [SLOTS_PER_CHUNK-1:0] free_wdata, free_rdata;
  logic                       gen_we;
  logic [SLOT_ADDR_W-1:0]     gen_waddr, gen_raddr;
  logic [GEN_BITS-1:0]        gen_wdata, gen_rdata;

  // Control and operand registers
  state_t                     state_r, state_nxt;
  logic [SLOT_ADDR_W-1:0]     clr_cnt_r, clr_cnt_nxt;
  logic [NUM_CHUNKS-1:0]      has_free_r, has_free_nxt;
  logic [USE_W-1:0]           in_use_r, in_use_nxt;
  logic [LIMIT_W-1:0]         limit_r;
  cmd_t                       cmd_r, cmd_nxt;
  logic [INDEX_W-1:0]         idx_r, idx_nxt;
  logic [HGEN_W-1:0]          hgen_r, hgen_nxt;
  logic [CHUNK_W-1:0]         chunk_r, chunk_nxt;
  logic [SLOT_W-1:0]          slot_r, slot_nxt;
  logic                       out_strobe_r, out_strobe_nxt;
  alloc_out_t                 out_r, out_nxt;

  // Shared find-first-set unit
  logic [NUM_CHUNKS-1:0]      ffs_in;
  logic [CHUNK_W-1:0]         ffs_idx;
  logic                       ffs_found;

  logic                       accept;
  logic [LIMIT_W-1:0]         limit_eff;
  logic                       room;
  logic                       live;
  logic [CHUNK_W-1:0]         h_chunk;
  logic [SLOT_W-1:0]          h_slot;
  logic [SLOTS_PER_CHUNK-1:0] slot_bit;
  logic [SLOTS_PER_CHUNK-1:0] cleared_word;

  assign busy       = (state_r != ST_IDLE);
  assign accept     = start && !busy;
  assign out_strobe = out_strobe_r;
  assign out_result = out_r;
  assign pready     = 1'b1;

  // Configuration port
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_W'(LIMIT_RESET);
    end else if (psel && penable && pwrite &&
                 (reg_idx_t'(paddr[PADDR_W-1]) == REG_CHUNK_LIMIT)) begin
      limit_r <= pwdata[LIMIT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_idx_t'(paddr[PADDR_W-1]) == REG_CHUNK_LIMIT) begin
      prdata = PDATA_W'(limit_r);
    end
  end

  assign limit_eff = (limit_r > LIMIT_W'(NUM_CHUNKS)) ? LIMIT_W'(NUM_CHUNKS) : limit_r;
  assign room      = (LIMIT_W'(in_use_r) < limit_eff);

  // Find-first-set over the selected vector
  always_comb begin
    ffs_in = has_free_r;
    if (state_r == ST_SLOT) begin
      ffs_in = NUM_CHUNKS'(free_rdata);
    end
  end

  always_comb begin
    ffs_idx   = '0;
    ffs_found = 1'b0;
    for (int i = NUM_CHUNKS - 1; i >= 0; i--) begin
      if (ffs_in[i]) begin
        ffs_idx   = CHUNK_W'(i);
        ffs_found = 1'b1;
      end
    end
  end

  // Handle lookup terms
  assign h_chunk      = idx_r[SLOT_ADDR_W-1:SLOT_W];
  assign h_slot       = idx_r[SLOT_W-1:0];
  assign slot_bit     = SLOTS_PER_CHUNK'(1) << h_slot;
  assign cleared_word = free_rdata & ~(SLOTS_PER_CHUNK'(1) << ffs_idx[SLOT_W-1:0]);
  assign live = ((cmd_r == CMD_KILL) || (cmd_r == CMD_CHECK)) &&
                (idx_r[INDEX_W-1:SLOT_W] < USE_W'(in_use_r)) &&
                (gen_rdata == hgen_r[GEN_BITS-1:0]) &&
                ((free_rdata & slot_bit) == '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == SLOT_ADDR_W'(TOTAL_SLOTS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_nxt = (in_item.cmd == CMD_SPAWN) ? ST_CHUNK : ST_LOOKUP;
      end
      ST_CHUNK: begin
        state_nxt = (ffs_found || room) ? ST_SLOT : ST_IDLE;
      end
      ST_SLOT: begin
        state_nxt = ffs_found ? ST_GEN : ST_IDLE;
      end
      ST_GEN:    state_nxt = ST_IDLE;
      ST_LOOKUP: state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    clr_cnt_nxt    = clr_cnt_r;
    has_free_nxt   = has_free_r;
    in_use_nxt     = in_use_r;
    cmd_nxt        = cmd_r;
    idx_nxt        = idx_r;
    hgen_nxt       = hgen_r;
    chunk_nxt      = chunk_r;
    slot_nxt       = slot_r;
    out_strobe_nxt = 1'b0;
    out_nxt        = out_r;
    free_we        = 1'b0;
    free_waddr     = chunk_r;
    free_wdata     = free_rdata;
    free_raddr     = chunk_r;
    gen_we         = 1'b0;
    gen_waddr      = idx_r[SLOT_ADDR_W-1:0];
    gen_wdata      = gen_rdata;
    gen_raddr      = {chunk_r, slot_r};
    unique case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + SLOT_ADDR_W'(1);
        free_we     = 1'b1;
        free_waddr  = clr_cnt_r[CHUNK_W-1:0];
        free_wdata  = '1;
        gen_we      = 1'b1;
        gen_waddr   = clr_cnt_r;
        gen_wdata   = '1;
      end
      ST_IDLE: begin
        free_raddr = in_item.handle_index[SLOT_ADDR_W-1:SLOT_W];
        gen_raddr  = in_item.handle_index[SLOT_ADDR_W-1:0];
        if (accept) begin
          cmd_nxt  = in_item.cmd;
          idx_nxt  = in_item.handle_index;
          hgen_nxt = in_item.handle_generation;
        end
      end
      ST_CHUNK: begin
        if (ffs_found) begin
          chunk_nxt  = ffs_idx;
          free_raddr = ffs_idx;
        end else if (room) begin
          // bring the next chunk into use; its free word is still all ones
          chunk_nxt  = in_use_r[CHUNK_W-1:0];
          free_raddr = in_use_r[CHUNK_W-1:0];
          has_free_nxt[in_use_r[CHUNK_W-1:0]] = 1'b1;
          in_use_nxt = in_use_r + USE_W'(1);
        end else begin
          out_strobe_nxt = 1'b1;
          out_nxt        = '{status: STS_FULL, given_index: '0,
                             given_generation: '0, is_live: 1'b0};
        end
      end
      ST_SLOT: begin
        if (ffs_found) begin
          slot_nxt   = ffs_idx[SLOT_W-1:0];
          gen_raddr  = {chunk_r, ffs_idx[SLOT_W-1:0]};
          free_we    = 1'b1;
          free_waddr = chunk_r;
          free_wdata = cleared_word;
          if (cleared_word == '0) has_free_nxt[chunk_r] = 1'b0;
        end else begin
          out_strobe_nxt = 1'b1;
          out_nxt        = '{status: STS_FULL, given_index: '0,
                             given_generation: '0, is_live: 1'b0};
        end
      end
      ST_GEN: begin
        out_strobe_nxt = 1'b1;
        out_nxt        = '{status: STS_OK,
                           given_index: INDEX_W'({chunk_r, slot_r}),
                           given_generation: HGEN_W'(gen_rdata),
                           is_live: 1'b0};
      end
      ST_LOOKUP: begin
        out_strobe_nxt = 1'b1;
        out_nxt        = '{status: live ? STS_OK : STS_INVALID, given_index: '0,
                           given_generation: '0, is_live: live};
        if (live && (cmd_r == CMD_KILL)) begin
          // free the slot and advance its generation
          gen_we     = 1'b1;
          gen_waddr  = idx_r[SLOT_ADDR_W-1:0];
          gen_wdata  = gen_rdata + GEN_BITS'(1);
          free_we    = 1'b1;
          free_waddr = h_chunk;
          free_wdata = free_rdata | slot_bit;
          has_free_nxt[h_chunk] = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_cnt_r    <= '0;
      has_free_r   <= NUM_CHUNKS'(1);
      in_use_r     <= USE_W'(1);
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      has_free_r   <= has_free_nxt;
      in_use_r     <= in_use_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    idx_r   <= idx_nxt;
    hgen_r  <= hgen_nxt;
    chunk_r <= chunk_nxt;
    slot_r  <= slot_nxt;
    out_r   <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (free_we) free_mem[free_waddr] <= free_wdata;
    free_rdata <= free_mem[free_raddr];
  end

  always_ff @(posedge clk) begin
    if (gen_we) gen_mem[gen_waddr] <= gen_wdata;
    gen_rdata <= gen_mem[gen_raddr];
  end

  `GSA_ASSERT(a_strobe_after_work, out_strobe |-> $past(busy))
  `GSA_ASSERT(a_accept_goes_busy, (start && !busy) |=> busy)
  `GSA_ASSERT(a_in_use_range, (in_use_r != '0) && (in_use_r <= USE_W'(NUM_CHUNKS)))
  `GSA_ASSERT(a_free_only_in_use, (has_free_r >> in_use_r) == '0)

endmodule
